>>> rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on the rising clock edge, held off during reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Assert that a condition never holds.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  `ASSERT_CLK(label, clk, rst_n, !(cond), msg)

`endif

>>> rtl/lmf_pkg.sv
package lmf_pkg;

  localparam logic [1:0] CMD_FILL    = 2'd0;
  localparam logic [1:0] CMD_DISPLAY = 2'd1;
  localparam logic [1:0] CMD_START   = 2'd2;
  localparam logic [1:0] CMD_STEP    = 2'd3;

  localparam int CFG_IW = 1;
  localparam logic [CFG_IW-1:0] CFG_ONE_CODE  = 1'b0;
  localparam logic [CFG_IW-1:0] CFG_ZERO_CODE = 1'b1;

  localparam logic [7:0] ONE_CODE_RST  = 8'hFC;
  localparam logic [7:0] ZERO_CODE_RST = 8'hF0;

  localparam logic [1:0] CH_GREEN = 2'd0;
  localparam logic [1:0] CH_RED   = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  typedef struct packed {
    logic fill;
    logic start;
    logic step;
    logic div_start;
    logic ch_store;
    logic row_next;
    logic emit_init;
    logic emit_load;
  } lmf_cmd_t;

  typedef struct packed {
    logic fade_active;
    logic row_due;
    logic row_last;
    logic ch_last;
    logic div_busy;
    logic out_free;
    logic emit_last;
  } lmf_stat_t;

  function automatic logic [63:0] encode_byte(input logic [7:0] b,
                                              input logic [7:0] one_c,
                                              input logic [7:0] zero_c);
    logic [63:0] w;
    w = '0;
    for (int i = 0; i < 8; i++) begin
      w[63-8*i -: 8] = b[7-i] ? one_c : zero_c;
    end
    return w;
  endfunction

endpackage

>>> rtl/lmf_div.sv
module lmf_div #(
  parameter int NW      = 15,
  parameter int TW      = 7,
  parameter int DIVISOR = 100
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] dividend_i,
  output logic          busy_o,
  output logic [7:0]    quot_o
);

  localparam int S  = NW + TW;
  localparam int PW = 2 * NW;
  localparam logic [PW-1:0] RECIP = PW'(((1 << S) + DIVISOR - 1) / DIVISOR);

  logic [NW-1:0] n_q, n_d;
  logic [7:0]    q_q, q_d;
  logic          busy_q, busy_d;

  always_comb begin
    n_d    = n_q;
    busy_d = 1'b0;
    if (start_i) begin
      n_d    = dividend_i;
      busy_d = 1'b1;
    end
    q_d = 8'((PW'(n_q) * RECIP) >> S);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d;
    q_q <= q_d;
  end

  assign busy_o = busy_q;
  assign quot_o = q_q;

endmodule

>>> rtl/lmf_dp.sv
module lmf_dp #(
  parameter int ROW_COUNT    = 4,
  parameter int LEDS_PER_ROW = 4,
  parameter int FADE_STEPS   = 100
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [lmf_pkg::CFG_IW-1:0] cfg_index_i,
  input  logic [7:0]                cfg_data_i,
  input  logic [7:0]                red_i,
  input  logic [7:0]                green_i,
  input  logic [7:0]                blue_i,
  input  lmf_pkg::lmf_cmd_t         cmd_i,
  output lmf_pkg::lmf_stat_t        stat_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [63:0]               code_word_o,
  output logic                      last_of_frame_o
);

  import lmf_pkg::*;

  localparam int RIW      = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam int PIW      = (LEDS_PER_ROW > 1) ? $clog2(LEDS_PER_ROW) : 1;
  localparam int TW       = $clog2(FADE_STEPS + 1);
  localparam int KW       = $clog2(2 * FADE_STEPS + 1);
  localparam int TSW      = KW + 2;
  localparam int NW       = 8 + TW;
  localparam int STAGGER  = FADE_STEPS / ROW_COUNT;
  localparam int FADE_END = 2 * FADE_STEPS;

  localparam logic [TSW-1:0] T_MAX  = TSW'(FADE_STEPS);
  localparam logic [TSW-1:0] T_STEP = TSW'(STAGGER);
  localparam logic [NW-1:0]  CEIL_BIAS = NW'(FADE_STEPS - 1);

  logic [7:0]        one_q, one_d, zero_q, zero_d;
  logic [23:0]       row_col_q [ROW_COUNT];
  logic [23:0]       row_col_d [ROW_COUNT];
  logic [23:0]       start_q, start_d;
  logic [8:0]        delta_q [3];
  logic [8:0]        delta_d [3];
  logic [KW-1:0]     k_q, k_d, k_n;
  logic              active_q, active_d;
  logic [TSW-1:0]    t_q, t_d;
  logic [RIW-1:0]    row_q, row_d;
  logic [PIW-1:0]    pix_q, pix_d;
  logic [1:0]        ch_q, ch_d;
  logic [7:0]        stg_q [2];
  logic [7:0]        stg_d [2];
  logic              neg_q, neg_d;
  logic [63:0]       out_q, out_d;
  logic              last_q, last_d;
  logic              ovalid_q, ovalid_d;

  logic [23:0]       rgb_in, row_rd;
  logic [7:0]        cur_start, cur_byte, mag8;
  logic [8:0]        cur_delta, mag;
  logic [NW-1:0]     prod, bias, dividend;
  logic [7:0]        quot;
  logic              div_busy;
  logic [9:0]        res, x;
  logic [7:0]        fade_val;
  logic              row_last, pix_last, ch_last, emit_last;

  assign rgb_in = {green_i, red_i, blue_i};
  assign row_rd = row_col_q[row_q];

  always_comb begin
    unique case (ch_q)
      CH_GREEN: begin
        cur_start = start_q[23:16];
        cur_delta = delta_q[0];
        cur_byte  = row_rd[23:16];
      end
      CH_RED: begin
        cur_start = start_q[15:8];
        cur_delta = delta_q[1];
        cur_byte  = row_rd[15:8];
      end
      default: begin
        cur_start = start_q[7:0];
        cur_delta = delta_q[2];
        cur_byte  = row_rd[7:0];
      end
    endcase
  end

  assign mag      = cur_delta[8] ? (9'd0 - cur_delta) : cur_delta;
  assign mag8     = mag[7:0];
  assign prod     = NW'(mag8) * NW'(t_q[TW-1:0]);
  // round the magnitude up for a falling channel
  assign bias     = cur_delta[8] ? CEIL_BIAS : '0;
  assign dividend = prod + bias;

  lmf_div #(
    .NW      (NW),
    .TW      (TW),
    .DIVISOR (FADE_STEPS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  assign res = neg_q ? (10'd0 - {2'b00, quot}) : {2'b00, quot};
  assign x   = {2'b00, cur_start} + res;

  always_comb begin
    if (x[9]) begin
      fade_val = 8'd0;
    end else if (x[8]) begin
      fade_val = 8'hFF;
    end else begin
      fade_val = x[7:0];
    end
  end

  assign row_last  = (row_q == RIW'(ROW_COUNT - 1));
  assign pix_last  = (pix_q == PIW'(LEDS_PER_ROW - 1));
  assign ch_last   = (ch_q == CH_BLUE);
  assign emit_last = row_last && pix_last && ch_last;
  assign k_n       = k_q + 1'b1;

  always_comb begin
    one_d     = one_q;
    zero_d    = zero_q;
    row_col_d = row_col_q;
    start_d   = start_q;
    delta_d   = delta_q;
    k_d       = k_q;
    active_d  = active_q;
    t_d       = t_q;
    row_d     = row_q;
    pix_d     = pix_q;
    ch_d      = ch_q;
    stg_d     = stg_q;
    neg_d     = neg_q;
    out_d     = out_q;
    last_d    = last_q;
    ovalid_d  = ovalid_q;

    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ONE_CODE:  one_d  = cfg_data_i;
        CFG_ZERO_CODE: zero_d = cfg_data_i;
        default: ;
      endcase
    end

    if (cmd_i.fill) begin
      for (int r = 0; r < ROW_COUNT; r++) begin
        row_col_d[r] = rgb_in;
      end
    end

    if (cmd_i.start) begin
      start_d    = row_col_q[0];
      delta_d[0] = {1'b0, green_i} - {1'b0, row_col_q[0][23:16]};
      delta_d[1] = {1'b0, red_i}   - {1'b0, row_col_q[0][15:8]};
      delta_d[2] = {1'b0, blue_i}  - {1'b0, row_col_q[0][7:0]};
      k_d        = '0;
      active_d   = 1'b1;
    end

    if (cmd_i.step) begin
      k_d      = k_n;
      t_d      = TSW'(k_n);
      active_d = (k_n != KW'(FADE_END));
      row_d    = '0;
      ch_d     = CH_GREEN;
    end

    if (cmd_i.div_start) begin
      neg_d = cur_delta[8];
    end

    if (cmd_i.ch_store) begin
      if (ch_last) begin
        row_col_d[row_q] = {stg_q[0], stg_q[1], fade_val};
      end else begin
        stg_d[ch_q[0]] = fade_val;
      end
      ch_d = ch_q + 1'b1;
    end

    if (cmd_i.row_next) begin
      row_d = row_q + 1'b1;
      t_d   = t_q - T_STEP;
      ch_d  = CH_GREEN;
    end

    if (out_ready_i && ovalid_q) begin
      ovalid_d = 1'b0;
    end

    if (cmd_i.emit_load) begin
      out_d    = encode_byte(cur_byte, one_q, zero_q);
      last_d   = emit_last;
      ovalid_d = 1'b1;
      if (ch_last) begin
        ch_d = CH_GREEN;
        if (pix_last) begin
          pix_d = '0;
          row_d = row_last ? '0 : row_q + 1'b1;
        end else begin
          pix_d = pix_q + 1'b1;
        end
      end else begin
        ch_d = ch_q + 1'b1;
      end
    end

    if (cmd_i.emit_init) begin
      row_d = '0;
      pix_d = '0;
      ch_d  = CH_GREEN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      one_q    <= ONE_CODE_RST;
      zero_q   <= ZERO_CODE_RST;
      for (int r = 0; r < ROW_COUNT; r++) begin
        row_col_q[r] <= '0;
      end
      start_q  <= '0;
      for (int c = 0; c < 3; c++) begin
        delta_q[c] <= '0;
      end
      k_q      <= '0;
      active_q <= 1'b0;
      row_q    <= '0;
      pix_q    <= '0;
      ch_q     <= CH_GREEN;
      ovalid_q <= 1'b0;
    end else begin
      one_q     <= one_d;
      zero_q    <= zero_d;
      row_col_q <= row_col_d;
      start_q   <= start_d;
      delta_q   <= delta_d;
      k_q       <= k_d;
      active_q  <= active_d;
      row_q     <= row_d;
      pix_q     <= pix_d;
      ch_q      <= ch_d;
      ovalid_q  <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q    <= t_d;
    stg_q  <= stg_d;
    neg_q  <= neg_d;
    out_q  <= out_d;
    last_q <= last_d;
  end

  assign stat_o.fade_active = active_q;
  assign stat_o.row_due     = !t_q[TSW-1] && (|t_q) && (t_q <= T_MAX);
  assign stat_o.row_last    = row_last;
  assign stat_o.ch_last     = ch_last;
  assign stat_o.div_busy    = div_busy;
  assign stat_o.out_free    = !ovalid_q || out_ready_i;
  assign stat_o.emit_last   = emit_last;

  assign out_valid_o     = ovalid_q;
  assign code_word_o     = out_q;
  assign last_of_frame_o = last_q;

endmodule

>>> rtl/lmf_ctrl.sv
module lmf_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [1:0]         cmd_i,
  output logic               in_ready_o,
  input  lmf_pkg::lmf_stat_t stat_i,
  output lmf_pkg::lmf_cmd_t  cmd_o
);

  import lmf_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ROW  = 3'd1;
  localparam logic [2:0] S_CH   = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = (state_q == S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (cmd_i)
            CMD_FILL:    cmd_o.fill = 1'b1;
            CMD_START:   cmd_o.start = 1'b1;
            CMD_DISPLAY: begin
              cmd_o.emit_init = 1'b1;
              state_d         = S_EMIT;
            end
            CMD_STEP: begin
              if (stat_i.fade_active) begin
                cmd_o.step = 1'b1;
                state_d    = S_ROW;
              end else begin
                cmd_o.emit_init = 1'b1;
                state_d         = S_EMIT;
              end
            end
            default: ;
          endcase
        end
      end
      S_ROW: begin
        if (stat_i.row_due) begin
          state_d = S_CH;
        end else if (stat_i.row_last) begin
          cmd_o.emit_init = 1'b1;
          state_d         = S_EMIT;
        end else begin
          cmd_o.row_next = 1'b1;
        end
      end
      S_CH: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV;
      end
      S_DIV: begin
        if (!stat_i.div_busy) begin
          cmd_o.ch_store = 1'b1;
          if (!stat_i.ch_last) begin
            state_d = S_CH;
          end else if (stat_i.row_last) begin
            cmd_o.emit_init = 1'b1;
            state_d         = S_EMIT;
          end else begin
            cmd_o.row_next = 1'b1;
            state_d        = S_ROW;
          end
        end
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit_load = 1'b1;
          if (stat_i.emit_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/led_matrix_fade_ws2812_encoder.sv
// Row-fading LED frame with a serial pulse-code encoder. The frame holds
// ROW_COUNT rows of LEDS_PER_ROW pixels (green, red, blue); all pixels of a
// row always share one colour, so one 24-bit register per row holds it.
// Fill and start-migration give no words and leave the block ready for the
// next command. Display gives ROW_COUNT*LEDS_PER_ROW*3 code words (48 by
// default), one per cycle while the output is taken; the command moves the
// controller to its emit state, which loads each word into the output
// register. A migration step first walks the rows: a row outside its fade
// window is passed over, and for a row inside it each of the three channels
// is scaled by a small multiply and divided by FADE_STEPS through a
// registered reciprocal multiply; then the frame follows as for display. A
// step while no migration runs goes straight to the frame. A new command is
// taken once the last word of a frame sits in the output register.
module led_matrix_fade_ws2812_encoder #(
  parameter int ROW_COUNT    = 4,
  parameter int LEDS_PER_ROW = 4,
  parameter int FADE_STEPS   = 100
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [lmf_pkg::CFG_IW-1:0] cfg_index_i,
  input  logic [7:0]                 cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 cmd_i,
  input  logic [7:0]                 red_i,
  input  logic [7:0]                 green_i,
  input  logic [7:0]                 blue_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [63:0]                code_word_o,
  output logic                       last_of_frame_o
);

  import lmf_pkg::*;

  lmf_cmd_t  cmd;
  lmf_stat_t stat;

  lmf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cmd_i      (cmd_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lmf_dp #(
    .ROW_COUNT    (ROW_COUNT),
    .LEDS_PER_ROW (LEDS_PER_ROW),
    .FADE_STEPS   (FADE_STEPS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .red_i           (red_i),
    .green_i         (green_i),
    .blue_i          (blue_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .code_word_o     (code_word_o),
    .last_of_frame_o (last_of_frame_o)
  );

endmodule

>>> rtl/lmf_checker.sv
`include "assert_macros.svh"

module lmf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [1:0]  cmd_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [63:0] code_word_o,
  input logic        last_of_frame_o
);

  import lmf_pkg::*;

  `ASSERT_CLK(a_fill_single_cycle, clk_i, rst_ni,
    in_valid_i && in_ready_o && cmd_i == CMD_FILL |=> in_ready_o, "fill blocked input")

  `ASSERT_CLK(a_display_busy, clk_i, rst_ni,
    in_valid_i && in_ready_o && cmd_i == CMD_DISPLAY |=> !in_ready_o, "display not started")

  `ASSERT_NEVER(a_no_accept_mid_frame, clk_i, rst_ni,
    out_valid_o && !last_of_frame_o && in_ready_o, "input taken mid-frame")

  `ASSERT_CLK(a_out_hold, clk_i, rst_ni,
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(code_word_o) &&
    $stable(last_of_frame_o), "stalled transaction changed")

endmodule

bind led_matrix_fade_ws2812_encoder lmf_checker u_lmf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .cmd_i           (cmd_i),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .code_word_o     (code_word_o),
  .last_of_frame_o (last_of_frame_o)
);
